// ----- design/swdt_pkg.sv -----
// ----------------------------------------------------------------------------
// swdt_pkg
// Shared widths, codes and types of the spread window deviation trigger.
// ----------------------------------------------------------------------------
package swdt_pkg;

  localparam int PRICE_W            = 32;
  localparam int SPREAD_W           = 33;
  localparam int LEN_W              = 9;
  localparam int THR_W              = 32;
  localparam int SIG_W              = 2;
  localparam int CFG_INDEX_W        = 1;
  localparam int CFG_DATA_W         = 32;
  localparam int LEN_MAX            = 2 ** LEN_W - 1;
  localparam int WINDOW_MAX_DEFAULT = 256;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);
  localparam logic [THR_W-1:0] THR_RESET = '0;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_THRESHOLD = 1'b1;

  localparam logic [SIG_W-1:0] SIG_NONE  = 2'd0;
  localparam logic [SIG_W-1:0] SIG_LONG  = 2'd1;
  localparam logic [SIG_W-1:0] SIG_SHORT = 2'd2;

  typedef logic signed [SPREAD_W-1:0] spread_t;

  typedef struct packed {
    logic    valid;
    logic    win_full;
    spread_t long_spread;
    spread_t short_spread;
  } issue_t;

  typedef struct packed {
    logic [SIG_W-1:0] open_signal;
    spread_t          long_spread;
    spread_t          short_spread;
  } result_t;

endpackage

// ----- design/swdt_ram.sv -----
// ----------------------------------------------------------------------------
// swdt_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module swdt_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/swdt_front.sv -----
// ----------------------------------------------------------------------------
// swdt_front
// Input side: spreads, window slot and fill tracking, window RAM access,
// and credit count against the result queue.
// ----------------------------------------------------------------------------
module swdt_front #(
  parameter int WINDOW_MAX = swdt_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [swdt_pkg::PRICE_W-1:0] first_bid_price,
  input  logic [swdt_pkg::PRICE_W-1:0] first_ask_price,
  input  logic [swdt_pkg::PRICE_W-1:0] second_bid_price,
  input  logic [swdt_pkg::PRICE_W-1:0] second_ask_price,
  input  logic                         word_popped,
  input  logic                         win_clear,
  input  logic [swdt_pkg::LEN_W-1:0]   eff_len,
  output swdt_pkg::issue_t             issue,
  output swdt_pkg::spread_t            old_long,
  output swdt_pkg::spread_t            old_short
);
  import swdt_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_next;
  logic [LEN_W-1:0]  fill_count;
  logic [OCC_W-1:0]  occupancy;
  logic              accept;
  logic              win_full;
  spread_t           ls;
  spread_t           ss;

  assign accept   = push && !full;
  assign full     = (occupancy == OCC_W'(QUEUE_DEPTH));
  assign ls       = $signed({1'b0, second_bid_price}) - $signed({1'b0, first_ask_price});
  assign ss       = $signed({1'b0, second_ask_price}) - $signed({1'b0, first_bid_price});
  assign win_full = (fill_count >= eff_len);

  assign slot      = (32'(write_slot) >= 32'(eff_len)) ? '0 : write_slot;
  assign slot_next = ((32'(slot) + 32'd1) >= 32'(eff_len)) ? '0 : SLOT_W'(32'(slot) + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (accept && !word_popped) begin
      occupancy <= occupancy + OCC_W'(1);
    end else if (!accept && word_popped) begin
      occupancy <= occupancy - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || win_clear) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (accept) begin
      write_slot <= slot_next;
      if (!win_full) begin
        fill_count <= fill_count + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    issue.win_full     <= win_full;
    issue.long_spread  <= ls;
    issue.short_spread <= ss;
    if (rst) begin
      issue.valid <= 1'b0;
    end else begin
      issue.valid <= accept;
    end
  end

  // read-first: the old entry of the slot comes out as the new one goes in
  swdt_ram #(
    .WIDTH (SPREAD_W),
    .DEPTH (WINDOW_MAX)
  ) u_long_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (ls),
    .raddr (slot),
    .rdata (old_long)
  );

  swdt_ram #(
    .WIDTH (SPREAD_W),
    .DEPTH (WINDOW_MAX)
  ) u_short_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (ss),
    .raddr (slot),
    .rdata (old_short)
  );

endmodule

// ----- design/swdt_back.sv -----
// ----------------------------------------------------------------------------
// swdt_back
// Execution side: scaled spreads, running sums and the deviation test.
// ----------------------------------------------------------------------------
module swdt_back #(
  parameter int WINDOW_MAX = swdt_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       win_clear,
  input  logic [swdt_pkg::LEN_W-1:0] eff_len,
  input  logic [swdt_pkg::THR_W-1:0] open_threshold,
  input  swdt_pkg::issue_t           issue,
  input  swdt_pkg::spread_t          old_long,
  input  swdt_pkg::spread_t          old_short,
  output logic                       result_valid,
  output swdt_pkg::result_t          result
);
  import swdt_pkg::*;

  localparam int NMAX   = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;
  localparam int SUM_W  = SPREAD_W + $clog2(NMAX);
  localparam int DIFF_W = SUM_W + 1;
  localparam int MUL_W  = SPREAD_W + LEN_W + 1;

  logic signed [MUL_W-1:0]      mul_long;
  logic signed [MUL_W-1:0]      mul_short;
  spread_t                      evict_long;
  spread_t                      evict_short;
  logic [LEN_W+THR_W-1:0]       lim_prod;

  logic                         s2_valid;
  logic                         s2_full;
  logic signed [SUM_W-1:0]      prod_long;
  logic signed [SUM_W-1:0]      prod_short;
  logic signed [SPREAD_W:0]     delta_long;
  logic signed [SPREAD_W:0]     delta_short;
  spread_t                      s2_long;
  spread_t                      s2_short;
  logic signed [DIFF_W-1:0]     pos_lim;
  logic signed [DIFF_W-1:0]     neg_lim;
  logic signed [SUM_W-1:0]      long_sum;
  logic signed [SUM_W-1:0]      short_sum;

  logic signed [DIFF_W-1:0]     diff_long;
  logic signed [DIFF_W-1:0]     diff_short;
  logic                         hit_long;
  logic                         hit_short;

  assign mul_long    = $signed({1'b0, eff_len}) * issue.long_spread;
  assign mul_short   = $signed({1'b0, eff_len}) * issue.short_spread;
  assign evict_long  = issue.win_full ? old_long : '0;
  assign evict_short = issue.win_full ? old_short : '0;
  assign lim_prod    = eff_len * open_threshold;

  always_ff @(posedge clk) begin
    pos_lim <= $signed(DIFF_W'(lim_prod));
    neg_lim <= -pos_lim;
  end

  always_ff @(posedge clk) begin
    s2_full     <= issue.win_full;
    prod_long   <= mul_long[SUM_W-1:0];
    prod_short  <= mul_short[SUM_W-1:0];
    delta_long  <= (SPREAD_W+1)'(issue.long_spread) - (SPREAD_W+1)'(evict_long);
    delta_short <= (SPREAD_W+1)'(issue.short_spread) - (SPREAD_W+1)'(evict_short);
    s2_long     <= issue.long_spread;
    s2_short    <= issue.short_spread;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue.valid;
    end
  end

  // |n*spread - sum| >= n*threshold, as two signed compares
  assign diff_long  = DIFF_W'(prod_long) - DIFF_W'(long_sum);
  assign diff_short = DIFF_W'(prod_short) - DIFF_W'(short_sum);
  assign hit_long   = s2_full && (diff_long >= pos_lim || diff_long <= neg_lim);
  assign hit_short  = s2_full && (diff_short >= pos_lim || diff_short <= neg_lim);

  always_ff @(posedge clk) begin
    if (rst || win_clear) begin
      long_sum  <= '0;
      short_sum <= '0;
    end else if (s2_valid) begin
      long_sum  <= long_sum + SUM_W'(delta_long);
      short_sum <= short_sum + SUM_W'(delta_short);
    end
  end

  always_comb begin
    result.long_spread  = s2_long;
    result.short_spread = s2_short;
    if (hit_long) begin
      result.open_signal = SIG_LONG;
    end else if (hit_short) begin
      result.open_signal = SIG_SHORT;
    end else begin
      result.open_signal = SIG_NONE;
    end
  end

  assign result_valid = s2_valid;

endmodule

// ----- design/swdt_fifo.sv -----
// ----------------------------------------------------------------------------
// swdt_fifo
// Small result queue between the execution side and the output port.
// ----------------------------------------------------------------------------
module swdt_fifo #(
  parameter int DEPTH = swdt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  swdt_pkg::result_t wr_word,
  input  logic              rd_en,
  output swdt_pkg::result_t rd_word,
  output logic              empty
);
  import swdt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty   = (count == '0);
  assign rd_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/spread_window_deviation_trigger.sv -----
// ----------------------------------------------------------------------------
// spread_window_deviation_trigger
// Moving-average deviation trigger on the long and short spreads of two
// instruments.
//
//   channel   handshake        payload
//   input     push / full      first/second bid and ask prices
//   result    pop / empty      open_signal, long_spread, short_spread
//   config    cfg_write        cfg_index, cfg_data
//
// One word per cycle sustained while full is low; a result reaches the result
// ports through the issue register, the s2 stage register and the result
// queue. Each word reads and writes its window slot in the same RAM cycle, so
// the window RAM port sets the rate. full rises once 4 words are accepted but
// not yet popped. After rst both windows are empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module spread_window_deviation_trigger #(
  parameter int WINDOW_MAX = swdt_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [swdt_pkg::PRICE_W-1:0]     first_bid_price,
  input  logic [swdt_pkg::PRICE_W-1:0]     first_ask_price,
  input  logic [swdt_pkg::PRICE_W-1:0]     second_bid_price,
  input  logic [swdt_pkg::PRICE_W-1:0]     second_ask_price,
  output logic                             empty,
  input  logic                             pop,
  output logic [swdt_pkg::SIG_W-1:0]       open_signal,
  output logic signed [swdt_pkg::SPREAD_W-1:0] long_spread,
  output logic signed [swdt_pkg::SPREAD_W-1:0] short_spread,
  input  logic                             cfg_write,
  input  logic [swdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [swdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import swdt_pkg::*;

  logic [LEN_W-1:0] window_length;
  logic [THR_W-1:0] open_threshold;
  logic [LEN_W-1:0] eff_len;
  logic             win_clear;
  logic             word_popped;
  logic             result_valid;
  issue_t           issue;
  spread_t          old_long;
  spread_t          old_short;
  result_t          result;
  result_t          head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= LEN_RESET;
      open_threshold <= THR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          window_length <= cfg_data[LEN_W-1:0];
        end
        REG_OPEN_THRESHOLD: begin
          open_threshold <= cfg_data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign win_clear = cfg_write && (cfg_index == REG_WINDOW_LENGTH);

  // zero means 1, above the RAM depth saturates
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = window_length;
    end
  end

  assign word_popped = pop && !empty;

  swdt_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .first_bid_price  (first_bid_price),
    .first_ask_price  (first_ask_price),
    .second_bid_price (second_bid_price),
    .second_ask_price (second_ask_price),
    .word_popped      (word_popped),
    .win_clear        (win_clear),
    .eff_len          (eff_len),
    .issue            (issue),
    .old_long         (old_long),
    .old_short        (old_short)
  );

  swdt_back #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .win_clear      (win_clear),
    .eff_len        (eff_len),
    .open_threshold (open_threshold),
    .issue          (issue),
    .old_long       (old_long),
    .old_short      (old_short),
    .result_valid   (result_valid),
    .result         (result)
  );

  swdt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (result_valid),
    .wr_word (result),
    .rd_en   (word_popped),
    .rd_word (head),
    .empty   (empty)
  );

  assign open_signal  = head.open_signal;
  assign long_spread  = head.long_spread;
  assign short_spread = head.short_spread;

endmodule

// ----- bench/spread_window_deviation_trigger_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spread_window_deviation_trigger_tb
// Self-checking bench for the spread window deviation trigger. Words go in
// through a push/full queue and results come back through pop/empty, both
// sides idling at random. A predictor keeps its own long and short spread
// windows and running sums, and each popped result is compared field by
// field with the oldest expected one. Phases cover the reset setting, a zero
// and a saturated window length, threshold extremes and threshold-only
// changes that keep the windows.
// ----------------------------------------------------------------------------
module spread_window_deviation_trigger_tb;
  import swdt_pkg::*;

  localparam int WIN_MAX     = WINDOW_MAX_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [PRICE_W-1:0] PMAX = '1;

  typedef struct {
    logic [PRICE_W-1:0] first_bid;
    logic [PRICE_W-1:0] first_ask;
    logic [PRICE_W-1:0] second_bid;
    logic [PRICE_W-1:0] second_ask;
  } quote_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [PRICE_W-1:0]     first_bid_price = '0;
  logic [PRICE_W-1:0]     first_ask_price = '0;
  logic [PRICE_W-1:0]     second_bid_price = '0;
  logic [PRICE_W-1:0]     second_ask_price = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [SIG_W-1:0]       open_signal;
  logic signed [SPREAD_W-1:0] long_spread;
  logic signed [SPREAD_W-1:0] short_spread;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  quote_t  quote_queue[$];
  result_t trigger_queue[$];
  int      errors = 0;
  int      cycle_count = 0;
  bit      steady = 1'b0;

  // predictor state
  longint           long_hist[WIN_MAX];
  longint           short_hist[WIN_MAX];
  longint           long_total;
  longint           short_total;
  int unsigned      next_slot;
  int unsigned      held;
  logic [LEN_W-1:0] win_len;
  logic [THR_W-1:0] threshold;

  spread_window_deviation_trigger #(.WINDOW_MAX(WIN_MAX)) dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .first_bid_price  (first_bid_price),
    .first_ask_price  (first_ask_price),
    .second_bid_price (second_bid_price),
    .second_ask_price (second_ask_price),
    .empty            (empty),
    .pop              (pop),
    .open_signal      (open_signal),
    .long_spread      (long_spread),
    .short_spread     (short_spread),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_quote(input quote_t q);
    quote_queue.insert(quote_queue.size(), q);
  endtask

  function automatic int unsigned active_length();
    if (win_len == 0) return 1;
    if (win_len > WIN_MAX) return WIN_MAX;
    return win_len;
  endfunction

  function automatic bit deviates(input longint spread, input longint total,
                                  input int unsigned n);
    longint diff;
    longint lim;
    diff = longint'(n) * spread - total;
    lim  = longint'(n) * longint'({32'd0, threshold});
    if (diff < 0) diff = -diff;
    return diff >= lim;
  endfunction

  function automatic void clear_windows();
    long_total  = 0;
    short_total = 0;
    next_slot   = 0;
    held        = 0;
  endfunction

  task automatic score_quote(input quote_t q);
    longint      ls;
    longint      ss;
    int unsigned n;
    int unsigned slot;
    result_t     r;
    ls = longint'({32'd0, q.second_bid}) - longint'({32'd0, q.first_ask});
    ss = longint'({32'd0, q.second_ask}) - longint'({32'd0, q.first_bid});
    n  = active_length();
    r.open_signal = SIG_NONE;
    if (held >= n) begin
      if (deviates(ls, long_total, n)) r.open_signal = SIG_LONG;
      else if (deviates(ss, short_total, n)) r.open_signal = SIG_SHORT;
    end
    slot = next_slot;
    if (slot >= n) slot = 0;
    if (held >= n) begin
      long_total  -= long_hist[slot];
      short_total -= short_hist[slot];
    end else begin
      held++;
    end
    long_hist[slot]  = ls;
    short_hist[slot] = ss;
    long_total  += ls;
    short_total += ss;
    slot++;
    if (slot >= n) slot = 0;
    next_slot = slot;
    r.long_spread  = spread_t'(ls);
    r.short_spread = spread_t'(ss);
    trigger_queue.insert(trigger_queue.size(), r);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (quote_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 36)) begin
      push             <= 1'b1;
      first_bid_price  <= quote_queue[0].first_bid;
      first_ask_price  <= quote_queue[0].first_ask;
      second_bid_price <= quote_queue[0].second_bid;
      second_ask_price <= quote_queue[0].second_ask;
    end else begin
      push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= steady || $urandom_range(0, 99) >= 36;
  end

  // monitor: check the popped word first, then record the accepted one
  always @(posedge clk) begin : monitor
    result_t want;
    quote_t  got;
    if (!rst && pop && !empty) begin
      if (trigger_queue.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = trigger_queue[0];
        trigger_queue.delete(0);
        if (open_signal !== want.open_signal)
          report_mismatch($sformatf("open_signal %0d, expected %0d",
                                    open_signal, want.open_signal));
        if (long_spread !== want.long_spread)
          report_mismatch($sformatf("long_spread %0d, expected %0d",
                                    long_spread, want.long_spread));
        if (short_spread !== want.short_spread)
          report_mismatch($sformatf("short_spread %0d, expected %0d",
                                    short_spread, want.short_spread));
      end
    end
    if (!rst && push && !full) begin
      got = quote_queue[0];
      quote_queue.delete(0);
      score_quote(got);
    end
  end

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_WINDOW_LENGTH) begin
      win_len = data[LEN_W-1:0];
      clear_windows();
    end else if (idx == REG_OPEN_THRESHOLD) begin
      threshold = data[THR_W-1:0];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    while (quote_queue.size() != 0 || trigger_queue.size() != 0) @(posedge clk);
  endtask

  function automatic quote_t make_quote(input logic [PRICE_W-1:0] fb,
                                        input logic [PRICE_W-1:0] fa,
                                        input logic [PRICE_W-1:0] sb,
                                        input logic [PRICE_W-1:0] sa);
    quote_t q;
    q.first_bid  = fb;
    q.first_ask  = fa;
    q.second_bid = sb;
    q.second_ask = sa;
    return q;
  endfunction

  // mostly quotes close to a base price, some fully random ones
  function automatic quote_t quote_near(input int unsigned base, input int unsigned jitter);
    if ($urandom_range(0, 9) == 0)
      return make_quote($urandom(), $urandom(), $urandom(), $urandom());
    return make_quote(base + $urandom_range(0, jitter), base + $urandom_range(0, jitter),
                      base + $urandom_range(0, jitter), base + $urandom_range(0, jitter));
  endfunction

  task automatic run_random(input bit set_len, input logic [LEN_W-1:0] len_value,
                            input logic [THR_W-1:0] thr, input int count,
                            input int unsigned jitter, input bit calm);
    logic [CFG_DATA_W-1:0] d;
    int unsigned           base;
    drain();
    if (set_len) begin
      d = $urandom();
      d[LEN_W-1:0] = len_value;
      write_register(REG_WINDOW_LENGTH, d);
    end
    write_register(REG_OPEN_THRESHOLD, thr);
    steady = calm;
    base = $urandom();
    repeat (count) queue_quote(quote_near(base, jitter));
    drain();
    steady = 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] d;
    win_len   = LEN_RESET;
    threshold = THR_RESET;
    clear_windows();
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset setting: window of 16, zero threshold, so the 17th word opens long
    repeat (4) begin
      queue_quote(make_quote('0, '0, '0, '0));
      queue_quote(make_quote(PMAX, PMAX, PMAX, PMAX));
      queue_quote(make_quote(PMAX, '0, PMAX, '0));
      queue_quote(make_quote('0, PMAX, '0, PMAX));
    end
    queue_quote(make_quote($urandom(), $urandom(), $urandom(), $urandom()));
    drain();

    // zero length acts as one; maximum threshold: short-only and long opens
    d = $urandom();
    d[LEN_W-1:0] = '0;
    write_register(REG_WINDOW_LENGTH, d);
    write_register(REG_OPEN_THRESHOLD, '1);
    queue_quote(make_quote(PMAX, '0, PMAX, '0));
    queue_quote(make_quote('0, '0, PMAX, PMAX));
    queue_quote(make_quote('0, '0, PMAX, PMAX));
    queue_quote(make_quote('0, PMAX, '0, PMAX));
    drain();

    run_random(1'b1, 9'd3, $urandom_range(0, 300), 40, 400, 1'b0);
    run_random(1'b0, 9'd0, $urandom_range(0, 200), 60, 400, 1'b1);
    run_random(1'b1, 9'd1, $urandom_range(0, 100), 30, 100, 1'b0);
    run_random(1'b1, 9'd511, $urandom_range(0, 50), 262, 200, 1'b0);
    run_random(1'b1, 9'd8, '1, 30, 1000, 1'b0);
    run_random(1'b1, 9'd2, '0, 30, 50, 1'b0);

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
